// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the silence run remover.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked every clock edge outside reset.
`define SRR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Checked every clock edge, reset included.
`define SRR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define SRR_ASSERT(lbl, clk, rst, prop)
`define SRR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- rtl/srr_pkg.sv -----
// Shared constants, types and helper functions of the silence run remover.
package srr_pkg;

   localparam int MAX_SILENCE_LEN = 32;
   localparam int SAMPLE_BITS     = 16;
   localparam int LEN_W           = $clog2(MAX_SILENCE_LEN + 1);
   localparam int ADDR_W          = (MAX_SILENCE_LEN > 1) ? $clog2(MAX_SILENCE_LEN) : 1;
   localparam int LEVEL_W         = 15;
   localparam int MINLEN_W        = 6;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 15;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_LEVEL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN       = 1'b1;

   // one result word
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   burst_last;
      logic                   stream_end;
   } rsp_word_type;

   // effective minimum run: zero acts as one, large values clip to buffer depth
   function automatic logic [LEN_W-1:0] eff_min(input logic [MINLEN_W-1:0] m);
      logic [LEN_W-1:0] r;
      if (m == '0) begin
         r = LEN_W'(1);
      end else if (int'(m) > MAX_SILENCE_LEN) begin
         r = LEN_W'(MAX_SILENCE_LEN);
      end else begin
         r = LEN_W'(m);
      end
      return r;
   endfunction

   // magnitude at full precision, compared against the level
   function automatic logic is_quiet(input logic [SAMPLE_BITS-1:0] s,
                                     input logic [LEVEL_W-1:0]     level);
      logic [SAMPLE_BITS-1:0] mag;
      mag = s[SAMPLE_BITS-1] ? (~s + SAMPLE_BITS'(1)) : s;
      return (32'(mag) <= 32'(level));
   endfunction

endpackage

// ----- rtl/srr_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
module srr_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data, updated only when rd_en is set
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/srr_out_fifo.sv -----
// Two-word output queue that decouples the flush sequencer from the receiver.
module srr_out_fifo
   import srr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  rsp_word_type push_word,
   input  logic         pop_ready,
   output logic         pop_valid,
   output rsp_word_type pop_word,
   output logic [1:0]   count
);

   rsp_word_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop_valid = (count_ff != 2'd0);
   assign pop_word  = slot_ff[rd_ptr_ff];
   assign pop       = pop_valid & pop_ready;
   assign count     = count_ff;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_valid) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- rtl/silence_run_remover.sv -----
// Silence run remover: drops quiet runs that reach the minimum length.
//
// req_ channel carries one signed sample per word, tlast on the final sample
// of a stream. rsp_ channel returns kept samples in order; tlast marks the
// last word caused by one input word, tuser marks the last word of a stream.
// csr_ port writes silence_level (index 0) and min_silence_length (index 1).
//
// Quiet samples of a run still below the minimum are written into a 32-entry
// held-sample RAM. When a loud sample or end of stream ends a short run, a
// sequencer reads the RAM back in order (registered read data), followed by
// the loud sample. A loud sample with nothing held passes through the flush
// state, the push register and the output queue before it is offered on rsp_.
// The sequencer issues a word only when the two-word output queue has room,
// counting a word still in flight; the next input word is taken once the
// flush has returned the sequencer to idle. A stalled receiver pauses the
// flush and, while the sequencer is busy, req_tready. Quiet samples that
// produce no output leave the sequencer idle. Reset (synchronous) clears the
// run count, the sequencer and the queue, and sets silence_level to 0 and
// min_silence_length to 1; RAM is not cleared.
`include "assert_macros.svh"

module silence_run_remover
   import srr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input words
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_BITS-1:0] req_tdata,   // [15:0] sample_in
   input  logic                   req_tlast,   // stream_last
   // result words
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [SAMPLE_BITS-1:0] rsp_tdata,   // [15:0] sample_out
   output logic                   rsp_tlast,   // burst_last
   output logic                   rsp_tuser,   // [0] stream_end
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_FLUSH = 1'b1;

   logic                   state_ff, state_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic [MINLEN_W-1:0]    min_len_ff, min_len_in;
   logic [LEN_W-1:0]       quiet_run_ff, quiet_run_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [LEN_W-1:0]       total_ff, total_in;
   logic [LEN_W-1:0]       cnt_ff, cnt_in;
   logic [SAMPLE_BITS-1:0] tail_sample_ff, tail_sample_in;
   logic                   last_ff, last_in;
   logic                   push_valid_ff, push_valid_in;
   logic                   from_ram_ff, from_ram_in;
   logic                   burst_ff, burst_in;
   logic                   end_ff, end_in;

   logic                   accept;
   logic                   quiet;
   logic [LEN_W-1:0]       minlen;
   logic                   run_lt_min;
   logic [LEN_W:0]         run_inc;
   logic                   credit;
   logic                   wr_en;
   logic                   rd_en;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic [1:0]             fifo_count;
   rsp_word_type           push_word;
   rsp_word_type           pop_word;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign minlen     = eff_min(min_len_ff);
   assign quiet      = is_quiet(req_tdata, level_ff);
   assign run_lt_min = (quiet_run_ff < minlen);
   assign run_inc    = {1'b0, quiet_run_ff} + (LEN_W+1)'(1);
   // room for one more word counting the one in flight
   assign credit     = (fifo_count == 2'd0) || ((fifo_count == 2'd1) && !push_valid_ff);

   // configuration registers
   always_comb begin
      level_in   = level_ff;
      min_len_in = min_len_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SILENCE_LEVEL: level_in   = csr_wdata[LEVEL_W-1:0];
            CSR_MIN_LEN:       min_len_in = csr_wdata[MINLEN_W-1:0];
            default:           ;
         endcase
      end
   end

   // run tracking and flush sequencer
   always_comb begin
      state_in       = state_ff;
      quiet_run_in   = quiet_run_ff;
      len_in         = len_ff;
      total_in       = total_ff;
      cnt_in         = cnt_ff;
      tail_sample_in = tail_sample_ff;
      last_in        = last_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      push_valid_in  = 1'b0;
      from_ram_in    = from_ram_ff;
      burst_in       = burst_ff;
      end_in         = end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tail_sample_in = req_tdata;
               last_in        = req_tlast;
               cnt_in         = '0;
               if (quiet) begin
                  if (run_lt_min) begin
                     if (run_inc >= {1'b0, minlen}) begin
                        // run long enough: held samples are dropped
                        quiet_run_in = minlen;
                     end else begin
                        wr_en        = 1'b1;
                        quiet_run_in = run_inc[LEN_W-1:0];
                        if (req_tlast) begin
                           len_in   = run_inc[LEN_W-1:0];
                           total_in = run_inc[LEN_W-1:0];
                           state_in = ST_FLUSH;
                        end
                     end
                  end
                  if (req_tlast) begin
                     quiet_run_in = '0;
                  end
               end else begin
                  // loud sample: release a short run, then the sample itself
                  len_in       = run_lt_min ? quiet_run_ff : '0;
                  total_in     = (run_lt_min ? quiet_run_ff : '0) + LEN_W'(1);
                  quiet_run_in = '0;
                  state_in     = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (credit) begin
               push_valid_in = 1'b1;
               from_ram_in   = (cnt_ff < len_ff);
               rd_en         = (cnt_ff < len_ff);
               burst_in      = (cnt_ff == total_ff - LEN_W'(1));
               end_in        = (cnt_ff == total_ff - LEN_W'(1)) & last_ff;
               cnt_in        = cnt_ff + LEN_W'(1);
               if (cnt_ff == total_ff - LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         level_ff      <= '0;
         min_len_ff    <= MINLEN_W'(1);
         quiet_run_ff  <= '0;
         push_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         level_ff      <= level_in;
         min_len_ff    <= min_len_in;
         quiet_run_ff  <= quiet_run_in;
         push_valid_ff <= push_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff         <= len_in;
      total_ff       <= total_in;
      cnt_ff         <= cnt_in;
      tail_sample_ff <= tail_sample_in;
      last_ff        <= last_in;
      from_ram_ff    <= from_ram_in;
      burst_ff       <= burst_in;
      end_ff         <= end_in;
   end

   // held-sample buffer
   srr_ram #(
      .DEPTH (MAX_SILENCE_LEN),
      .WIDTH (SAMPLE_BITS),
      .AW    (ADDR_W)
   ) u_held (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (quiet_run_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // word pushed in the cycle after issue, when RAM data is ready
   always_comb begin
      push_word.sample     = from_ram_ff ? rd_data : tail_sample_ff;
      push_word.burst_last = burst_ff;
      push_word.stream_end = end_ff;
   end

   srr_out_fifo u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid_ff),
      .push_word  (push_word),
      .pop_ready  (rsp_tready),
      .pop_valid  (rsp_tvalid),
      .pop_word   (pop_word),
      .count      (fifo_count)
   );

   assign rsp_tdata = pop_word.sample;
   assign rsp_tlast = pop_word.burst_last;
   assign rsp_tuser = pop_word.stream_end;

   // checks
   `SRR_ASSERT(a_run_bound, clock, reset, quiet_run_ff <= LEN_W'(MAX_SILENCE_LEN))
   `SRR_ASSERT(a_no_overflow, clock, reset, push_valid_ff |-> (fifo_count != 2'd2))
   `SRR_ASSERT(a_loud_flush, clock, reset, (accept && !quiet) |=> (state_ff == ST_FLUSH))

endmodule
